// ----- hw/rtl/lbfc_pkg.sv -----
// Shared types, constants and reciprocal dividers of the loss-based rate controller.
package lbfc_pkg;

   localparam int RATE_W  = 32;
   localparam int LOSS_W  = 7;
   localparam int TIME_W  = 64;
   localparam int COUNT_W = 3;
   localparam int CSR_INDEX_W = 2;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((LOSS_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 + RATE_W + 7) / 8) * 8;

   // Register reset values
   localparam logic [RATE_W-1:0] MIN_RATE_RESET   = 32'd1000000;
   localparam logic [RATE_W-1:0] MAX_RATE_RESET   = 32'd50000000;
   localparam logic [RATE_W-1:0] START_RATE_RESET = 32'd10000000;
   localparam logic [RATE_W-1:0] RISE_STEP_RESET  = MAX_RATE_RESET / 20;

   // Loss thresholds in percent
   localparam logic [LOSS_W-1:0] LOSS_HEAVY = 7'd5;
   localparam logic [LOSS_W-1:0] LOSS_MID   = 7'd2;
   localparam logic [LOSS_W-1:0] LOSS_LOW   = 7'd1;

   // Clean-report counter
   localparam logic [COUNT_W-1:0] CLEAN_MAX = 3'd7;
   localparam logic [COUNT_W-1:0] CLEAN_OFF = 3'd5;

   // Hold-off after a decrease, in microseconds
   localparam logic [TIME_W-1:0] HOLD_US = 64'd2000000;

   // Reciprocals: exact for every 32-bit dividend
   localparam logic [RATE_W-1:0] RECIP_10 = 32'hCCCCCCCD;  // shift 35
   localparam logic [RATE_W-1:0] RECIP_20 = 32'hCCCCCCCD;  // shift 36
   localparam logic [RATE_W-1:0] RECIP_50 = 32'h51EB851F;  // shift 36

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_RATE   = 2'd0,
      CSR_MAX_RATE   = 2'd1,
      CSR_START_RATE = 2'd2
   } lbfc_csr_index_type;

   typedef struct packed {
      logic [RATE_W-1:0] min_rate;
      logic [RATE_W-1:0] max_rate;
      logic [RATE_W-1:0] rise_step;
   } lbfc_cfg_type;

   typedef struct packed {
      logic              valid;
      logic [RATE_W-1:0] rate;
   } lbfc_load_type;

   typedef struct packed {
      logic [RATE_W-1:0]  current_rate;
      logic               fec_flag;
      logic [COUNT_W-1:0] clean_count;
      logic [TIME_W-1:0]  last_dec_us;
   } lbfc_state_type;

   typedef struct packed {
      logic              fec_on;
      logic              fec_changed;
      logic              rate_changed;
      logic [RATE_W-1:0] rate_bps;
   } lbfc_result_type;

   function automatic logic [RATE_W-1:0] div10(input logic [RATE_W-1:0] x);
      logic [2*RATE_W-1:0] p;
      p = {{RATE_W{1'b0}}, x} * {{RATE_W{1'b0}}, RECIP_10};
      return RATE_W'(p >> 35);
   endfunction

   function automatic logic [RATE_W-1:0] div20(input logic [RATE_W-1:0] x);
      logic [2*RATE_W-1:0] p;
      p = {{RATE_W{1'b0}}, x} * {{RATE_W{1'b0}}, RECIP_20};
      return RATE_W'(p >> 36);
   endfunction

   function automatic logic [RATE_W-1:0] div50(input logic [RATE_W-1:0] x);
      logic [2*RATE_W-1:0] p;
      p = {{RATE_W{1'b0}}, x} * {{RATE_W{1'b0}}, RECIP_50};
      return RATE_W'(p >> 36);
   endfunction

endpackage

// ----- hw/rtl/loss_based_bitrate_fec_control.sv -----
// Top level of the loss-based bitrate and FEC controller.
//
// Usage:
//   req_*  : one loss report per transaction; tdata = loss_percent[6:0],
//            now_us[70:7], zero pad.
//   rsp_*  : one decision per report, in order; tdata = fec_on[0],
//            fec_changed[1], rate_changed[2], rate_bps[34:3], zero pad.
//   csr_*  : register writes (0 min_rate, 1 max_rate, 2 start_rate); a write
//            to start_rate also loads the current bitrate. csr_ready is
//            always high. Write only while no report is in flight.
// Path: a report passes the input register, then the result register, before
// rsp_tvalid rises. Throughput: one report per cycle while the receiver keeps
// up; the controller state is updated in the same cycle the decision is registered.
// A stalled receiver holds the result register; the input register still
// takes one more report, then req_tready drops until rsp_tready returns.
// Reset empties both pipeline registers and returns registers and state to
// their defaults (current bitrate 10 Mb/s, FEC off, no decrease recorded).
module loss_based_bitrate_fec_control (
   input  logic                                  clock,
   input  logic                                  reset,
   // loss_percent[6:0], now_us[70:7]
   input  logic [lbfc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fec_on[0], fec_changed[1], rate_changed[2], rate_bps[34:3]
   output logic [lbfc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lbfc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lbfc_pkg::RATE_W-1:0]           csr_wdata
);
   import lbfc_pkg::*;

   lbfc_cfg_type    cfg;
   lbfc_load_type   load;
   lbfc_state_type  state_ff, state_in, state_calc;
   lbfc_result_type result_calc;
   lbfc_result_type res_ff, res_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [LOSS_W-1:0] s1_loss_ff, s1_loss_in;
   logic [TIME_W-1:0] s1_now_ff, s1_now_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   logic              req_take;
   logic              s1_fire;

   lbfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .load      (load)
   );

   lbfc_decide u_decide (
      .cfg          (cfg),
      .cur_state    (state_ff),
      .loss_percent (s1_loss_ff),
      .now_us       (s1_now_ff),
      .next_state   (state_calc),
      .result       (result_calc)
   );

   // Handshake: result register frees when empty or taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_loss_in  = s1_loss_ff;
      s1_now_in   = s1_now_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_loss_in  = req_tdata[LOSS_W-1:0];
         s1_now_in   = req_tdata[LOSS_W +: TIME_W];
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Controller state: advance with each report, reload on start_rate write
   always_comb begin
      state_in = state_ff;
      if (s1_fire) begin
         state_in = state_calc;
      end
      if (load.valid) begin
         state_in.current_rate = load.rate;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_in       = res_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         res_in       = result_calc;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         state_ff.current_rate <= START_RATE_RESET;
         state_ff.fec_flag     <= 1'b0;
         state_ff.clean_count  <= '0;
         state_ff.last_dec_us  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      s1_loss_ff <= s1_loss_in;
      s1_now_ff  <= s1_now_in;
      res_ff     <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RATE_W - 3){1'b0}}, res_ff.rate_bps,
                        res_ff.rate_changed, res_ff.fec_changed, res_ff.fec_on};

   // Input register stalls only when it holds a report
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   // A report leaving the input register always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("decision lost on its way to the result register");

   // Stored FEC flag matches the decision just registered
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (state_ff.fec_flag == res_ff.fec_on))
      else $error("FEC state and reported FEC disagree");

   // Any loss clears the clean counter and turns FEC on
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_loss_ff != '0)) |=> (state_ff.clean_count == '0 && state_ff.fec_flag))
      else $error("loss report did not reset FEC hysteresis");

endmodule

// ----- hw/rtl/lbfc_csr.sv -----
// Configuration registers: rate bounds, precomputed rise step and start-rate load.
module lbfc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbfc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lbfc_pkg::RATE_W-1:0]       csr_wdata,
   output lbfc_pkg::lbfc_cfg_type            cfg,
   output lbfc_pkg::lbfc_load_type           load
);
   import lbfc_pkg::*;

   lbfc_cfg_type cfg_ff, cfg_in;
   logic         wr;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   // Decode the write; keep max_rate/20 ready for the rise
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (lbfc_csr_index_type'(csr_index))
            CSR_MIN_RATE: begin
               cfg_in.min_rate = csr_wdata;
            end
            CSR_MAX_RATE: begin
               cfg_in.max_rate  = csr_wdata;
               cfg_in.rise_step = div20(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_rate  <= MIN_RATE_RESET;
         cfg_ff.max_rate  <= MAX_RATE_RESET;
         cfg_ff.rise_step <= RISE_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   assign load.valid = wr && (csr_index == CSR_START_RATE);
   assign load.rate  = csr_wdata;

endmodule

// ----- hw/rtl/lbfc_decide.sv -----
// Decision logic for one loss report: FEC hysteresis, AIMD step, clamp and threshold.
module lbfc_decide (
   input  lbfc_pkg::lbfc_cfg_type            cfg,
   input  lbfc_pkg::lbfc_state_type          cur_state,
   input  logic [lbfc_pkg::LOSS_W-1:0]       loss_percent,
   input  logic [lbfc_pkg::TIME_W-1:0]       now_us,
   output lbfc_pkg::lbfc_state_type          next_state,
   output lbfc_pkg::lbfc_result_type         result
);
   import lbfc_pkg::*;

   logic [RATE_W-1:0]  cur;
   logic [RATE_W-1:0]  cut_quarter;
   logic [RATE_W-1:0]  cut_tenth;
   logic [RATE_W-1:0]  min_step;
   logic [RATE_W:0]    cand;
   logic [RATE_W-1:0]  bounded;
   logic [RATE_W-1:0]  delta;
   logic [COUNT_W-1:0] count_next;
   logic               fec_next;
   logic               heavy;
   logic               mid;
   logic               elapsed;
   logic               apply;

   assign cur         = cur_state.current_rate;
   assign cut_quarter = cur - (cur >> 2);
   assign cut_tenth   = cur - div10(cur);
   assign min_step    = div50(cur);

   assign heavy   = loss_percent >= LOSS_HEAVY;
   assign mid     = loss_percent >= LOSS_MID;
   assign elapsed = (now_us - cur_state.last_dec_us) > HOLD_US;

   // FEC: on at any loss, off after enough clean reports
   always_comb begin
      count_next = cur_state.clean_count;
      fec_next   = cur_state.fec_flag;
      if (loss_percent >= LOSS_LOW) begin
         count_next = '0;
         fec_next   = 1'b1;
      end else begin
         if (cur_state.clean_count < CLEAN_MAX) begin
            count_next = cur_state.clean_count + 1'b1;
         end
         if (count_next >= CLEAN_OFF) begin
            fec_next = 1'b0;
         end
      end
   end

   // Pick the candidate rate, keeping the carry of the rise
   always_comb begin
      if (heavy) begin
         cand = {1'b0, cut_quarter};
      end else if (mid) begin
         cand = {1'b0, cut_tenth};
      end else if (elapsed) begin
         cand = {1'b0, cur} + {1'b0, cfg.rise_step};
      end else begin
         cand = {1'b0, cur};
      end
   end

   // Clamp to max first, then min so min wins
   always_comb begin
      if (cand > {1'b0, cfg.max_rate}) begin
         bounded = cfg.max_rate;
      end else begin
         bounded = cand[RATE_W-1:0];
      end
      if (bounded < cfg.min_rate) begin
         bounded = cfg.min_rate;
      end
   end

   assign delta = (bounded > cur) ? (bounded - cur) : (cur - bounded);
   assign apply = (bounded != cur) && (delta >= min_step);

   // Assemble next state and the result
   always_comb begin
      next_state.current_rate = apply ? bounded : cur;
      next_state.fec_flag     = fec_next;
      next_state.clean_count  = count_next;
      next_state.last_dec_us  = mid ? now_us : cur_state.last_dec_us;

      result.fec_on       = fec_next;
      result.fec_changed  = fec_next ^ cur_state.fec_flag;
      result.rate_changed = apply;
      result.rate_bps     = next_state.current_rate;
   end

endmodule
